FILE: sv/frl_pkg.sv
package frl_pkg;

  localparam int unsigned MAX_LABELS = 64;
  localparam int unsigned LabelW     = $clog2(MAX_LABELS);
  localparam int unsigned CountW     = $clog2(MAX_LABELS + 1);

  typedef logic [LabelW-1:0] label_t;
  typedef logic [CountW-1:0] count_t;

  localparam count_t CountMax = count_t'(MAX_LABELS);

  // item held in the input stage, with its table entry already read
  typedef struct packed {
    logic   valid;
    label_t label;
    logic   last;
    label_t number;
  } stage_t;

  // table write issued when a label is numbered for the first time
  typedef struct packed {
    logic   en;
    label_t label;
    label_t number;
  } tbl_wr_t;

endpackage

FILE: sv/frl_front.sv
module frl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  frl_pkg::label_t in_label_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  logic            advance_i,
  input  frl_pkg::tbl_wr_t wr_i,
  output frl_pkg::stage_t stage_o
);

  frl_pkg::label_t number_mem [frl_pkg::MAX_LABELS];

  logic            valid_q;
  frl_pkg::label_t label_q;
  logic            last_q;
  frl_pkg::label_t number_q;
  logic            load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // read at transfer; take the number being written this edge if it is the same label
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      number_mem[wr_i.label] <= wr_i.number;
    end
    if (load) begin
      label_q  <= in_label_i;
      last_q   <= in_last_i;
      number_q <= (wr_i.en && (wr_i.label == in_label_i)) ? wr_i.number
                                                          : number_mem[in_label_i];
    end
  end

  assign stage_o = '{valid: valid_q, label: label_q, last: last_q, number: number_q};

endmodule

FILE: sv/frl_core.sv
module frl_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  frl_pkg::stage_t  stage_i,
  output logic             advance_o,
  output frl_pkg::tbl_wr_t wr_o,
  input  logic             cfg_valid_i,
  input  frl_pkg::count_t  cfg_data_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output frl_pkg::label_t  out_dense_o,
  output logic             out_first_o,
  output logic             out_all_found_o,
  output logic             out_oor_o,
  output logic             out_end_o
);

  logic [frl_pkg::MAX_LABELS-1:0] seen_q, seen_d;
  frl_pkg::count_t found_q, found_d;
  frl_pkg::count_t label_count_q;
  frl_pkg::count_t eff_count;
  logic            complete_q, complete_d;
  logic            in_range, first;
  frl_pkg::label_t dense;

  logic            out_valid_q;
  frl_pkg::label_t dense_q;
  logic            first_q, all_found_q, oor_q, end_q;

  assign advance_o = stage_i.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    eff_count = (label_count_q > frl_pkg::CountMax) ? frl_pkg::CountMax : label_count_q;
    in_range  = {1'b0, stage_i.label} < label_count_q;
    first     = in_range && !seen_q[stage_i.label];
    found_d   = found_q + frl_pkg::count_t'(first);
    if (!in_range) begin
      dense = '0;
    end else if (first) begin
      dense = found_q[frl_pkg::LabelW-1:0];
    end else begin
      dense = stage_i.number;
    end
    complete_d = complete_q || (in_range && (found_d >= eff_count));
    seen_d     = seen_q;
    if (first) begin
      seen_d[stage_i.label] = 1'b1;
    end
  end

  assign wr_o = '{en: advance_o && first, label: stage_i.label,
                  number: found_q[frl_pkg::LabelW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_count_q <= frl_pkg::CountMax;
    end else if (cfg_valid_i) begin
      label_count_q <= cfg_data_i;
    end
  end

  // update the batch state per transferred item; clear it after the last item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      found_q    <= '0;
      complete_q <= 1'b0;
    end else if (advance_o) begin
      if (stage_i.last) begin
        seen_q     <= '0;
        found_q    <= '0;
        complete_q <= 1'b0;
      end else begin
        seen_q     <= seen_d;
        found_q    <= found_d;
        complete_q <= complete_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      dense_q     <= dense;
      first_q     <= first;
      all_found_q <= complete_d;
      oor_q       <= !in_range;
      end_q       <= stage_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_dense_o     = dense_q;
  assign out_first_o     = first_q;
  assign out_all_found_o = all_found_q;
  assign out_oor_o       = oor_q;
  assign out_end_o       = end_q;

endmodule

FILE: sv/first_occurrence_relabel_top.sv
// Dense relabeling of a batch of labels by order of first appearance.
// Input stream: one label per transfer in s_axis_tdata, s_axis_tlast marks the
// last label of a batch. Output stream: one result per input transfer, with the
// dense number in m_axis_tdata, flags first_seen / all_found / out_of_range in
// m_axis_tuser and the batch end echoed on m_axis_tlast.
// Configuration: cfg_data_i carries label_count; write it only while idle.
// From input transfer to result transfer the path is one input register, which
// also holds the number-table read, then the result register.
// Throughput is one label per cycle while the receiver accepts results; the seen
// flags are flops and the number table has one write and one read port per cycle,
// with the write forwarded to a read of the same label.
// When the receiver stalls, the result register holds and s_axis_tready drops
// only once the input register is also occupied.
// Reset clears the seen flags, found count and completion flag and sets
// label_count to 64; the number table needs no clearing since an entry is only
// read after its seen flag is set. All but label_count clear after each tlast.
module first_occurrence_relabel_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [5:0] label, [7:6] zero
  input  logic       s_axis_tlast,  // batch_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [5:0] dense_number, [7:6] zero
  output logic [2:0] m_axis_tuser,  // [0] first_seen, [1] all_found, [2] out_of_range
  output logic       m_axis_tlast,  // batch_end
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i     // label_count
);

  frl_pkg::stage_t  stage;
  frl_pkg::tbl_wr_t wr;
  frl_pkg::label_t  dense;
  logic             advance;

  frl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_label_i (s_axis_tdata[frl_pkg::LabelW-1:0]),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .advance_i  (advance),
    .wr_i       (wr),
    .stage_o    (stage)
  );

  frl_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stage_i         (stage),
    .advance_o       (advance),
    .wr_o            (wr),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_dense_o     (dense),
    .out_first_o     (m_axis_tuser[0]),
    .out_all_found_o (m_axis_tuser[1]),
    .out_oor_o       (m_axis_tuser[2]),
    .out_end_o       (m_axis_tlast)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {2'b00, dense};

endmodule
